// ===== rtl/core/heightmap_chunk_parser_defines.svh =====
`ifndef HEIGHTMAP_CHUNK_PARSER_DEFINES_SVH
`define HEIGHTMAP_CHUNK_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCP_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hcp check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hcp check failed");

`endif

// ===== rtl/core/hcp_pkg.sv =====
package hcp_pkg;

  localparam int unsigned DIM_FIELD_W = 17;

  typedef enum logic [3:0] {
    PH_MARK    = 4'd0,
    PH_SIZE    = 4'd1,
    PH_XPTS    = 4'd2,
    PH_YPTS    = 4'd3,
    PH_SKIP    = 4'd4,
    PH_SCALE   = 4'd5,
    PH_BASE    = 4'd6,
    PH_SAMPLES = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER     = 3'd0,
    KIND_SAMPLE     = 3'd1,
    KIND_END        = 3'd2,
    KIND_UNEXPECTED = 3'd3,
    KIND_TRUNCATED  = 3'd4
  } kind_e;

  localparam logic [63:0] MARK_TERRAGEN = 64'h54455252_4147454E;
  localparam logic [63:0] MARK_TERRAIN  = 64'h54455252_41494E20;
  localparam logic [31:0] MARK_SIZE     = 32'h53495A45;
  localparam logic [31:0] MARK_XPTS     = 32'h58505453;
  localparam logic [31:0] MARK_YPTS     = 32'h59505453;
  localparam logic [31:0] MARK_SCAL     = 32'h5343414C;
  localparam logic [31:0] MARK_CRAD     = 32'h43524144;
  localparam logic [31:0] MARK_CRVM     = 32'h4352564D;
  localparam logic [31:0] MARK_ALTW     = 32'h414C5457;
  localparam logic [31:0] MARK_EOF      = 32'h454F4620;

  localparam logic [3:0] LEN_WORD  = 4'd4;
  localparam logic [3:0] LEN_SCAL  = 4'd12;
  localparam logic [3:0] LEN_HALF  = 4'd2;
  localparam logic [3:0] LEN_SIG   = 4'd8;

  localparam logic [15:0] SAMPLE_FLIP = 16'h8000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e                   kind;
    logic [15:0]             sample;
    logic [DIM_FIELD_W-1:0]  width_points;
    logic [DIM_FIELD_W-1:0]  height_points;
    logic signed [15:0]      height_scale;
    logic signed [15:0]      base_height;
    logic                    last_sample;
  } out_item_t;

  typedef struct packed {
    logic       set_signature;
    logic       set_terrain;
    logic       start;
    phase_e     phase;
    logic [3:0] len;
    logic       stop;
    kind_e      stop_kind;
  } mark_dec_t;

endpackage

// ===== rtl/core/hcp_marker_dec.sv =====
module hcp_marker_dec (
  input  logic [63:0]        marker_i,
  input  logic               seen_signature_i,
  input  logic               seen_terrain_i,
  input  logic               seen_size_i,
  output hcp_pkg::mark_dec_t dec_o
);

  logic [31:0] word;

  assign word = marker_i[31:0];

  always_comb begin
    dec_o           = '0;
    dec_o.phase     = hcp_pkg::PH_MARK;
    dec_o.stop_kind = hcp_pkg::KIND_UNEXPECTED;
    if (!seen_terrain_i) begin
      if (!seen_signature_i && marker_i == hcp_pkg::MARK_TERRAGEN) begin
        dec_o.set_signature = 1'b1;
      end else if (seen_signature_i && marker_i == hcp_pkg::MARK_TERRAIN) begin
        dec_o.set_terrain = 1'b1;
      end else begin
        dec_o.stop = 1'b1;
        if (marker_i[63:32] == hcp_pkg::MARK_EOF) begin
          dec_o.stop_kind = hcp_pkg::KIND_END;
        end
      end
    end else begin
      if (word == hcp_pkg::MARK_SIZE) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_SIZE;
        dec_o.len   = hcp_pkg::LEN_WORD;
      end else if (seen_size_i && word == hcp_pkg::MARK_XPTS) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_XPTS;
        dec_o.len   = hcp_pkg::LEN_WORD;
      end else if (seen_size_i && word == hcp_pkg::MARK_YPTS) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_YPTS;
        dec_o.len   = hcp_pkg::LEN_WORD;
      end else if (seen_size_i && word == hcp_pkg::MARK_SCAL) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_SKIP;
        dec_o.len   = hcp_pkg::LEN_SCAL;
      end else if (seen_size_i && (word == hcp_pkg::MARK_CRAD ||
                                   word == hcp_pkg::MARK_CRVM)) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_SKIP;
        dec_o.len   = hcp_pkg::LEN_WORD;
      end else if (seen_size_i && word == hcp_pkg::MARK_ALTW) begin
        dec_o.start = 1'b1;
        dec_o.phase = hcp_pkg::PH_SCALE;
        dec_o.len   = hcp_pkg::LEN_HALF;
      end else begin
        dec_o.stop = 1'b1;
        if (word == hcp_pkg::MARK_EOF) begin
          dec_o.stop_kind = hcp_pkg::KIND_END;
        end
      end
    end
  end

endmodule

// ===== rtl/core/hcp_parser.sv =====
module hcp_parser #(
  parameter int unsigned DIM_BITS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  hcp_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output hcp_pkg::out_item_t res_o
);

  localparam int unsigned DimFieldW = hcp_pkg::DIM_FIELD_W;
  localparam logic [16:0] DIM_MAX = 17'((1 << DIM_BITS) - 1);

  hcp_pkg::phase_e     phase_q, phase_d, cur_phase;
  logic [63:0]         shift_q, shift_d, cur_shift, mark_new;
  logic [3:0]          bif_q, bif_d, cur_bif, bif_inc, mark_len;
  logic [3:0]          skip_q, skip_d, cur_skip;
  logic [7:0]          low_q, low_d, cur_low;
  logic                sig_q, sig_d, cur_sig;
  logic                terr_q, terr_d, cur_terr;
  logic                size_q, size_d, cur_size;
  logic                halted_q, halted_d, cur_halted;
  logic [DIM_BITS-1:0] x_q, x_d, cur_x;
  logic [DIM_BITS-1:0] y_q, y_d, cur_y;
  logic [DIM_BITS-1:0] col_q, col_d, cur_col;
  logic [DIM_BITS-1:0] row_q, row_d, cur_row;
  logic [15:0]         scale_q, scale_d, cur_scale;
  logic [15:0]         base_q, base_d, cur_base;
  logic [15:0]         word_new;
  logic [16:0]         dim_raw, dim_sat;
  logic [DIM_BITS:0]   col_inc, row_inc, x_ext, y_ext;
  hcp_pkg::mark_dec_t  dec;
  hcp_pkg::kind_e      kind;
  logic                res_on;
  logic [15:0]         smp;
  logic                last;
  logic                first;

  assign first = item_i.first_byte;

  // A first byte restarts the parse before the byte is taken.
  always_comb begin
    if (first) begin
      cur_phase  = hcp_pkg::PH_MARK;
      cur_shift  = '0;
      cur_bif    = '0;
      cur_skip   = '0;
      cur_low    = '0;
      cur_sig    = 1'b0;
      cur_terr   = 1'b0;
      cur_size   = 1'b0;
      cur_halted = 1'b0;
      cur_x      = '0;
      cur_y      = '0;
      cur_col    = '0;
      cur_row    = '0;
      cur_scale  = '0;
      cur_base   = '0;
    end else begin
      cur_phase  = phase_q;
      cur_shift  = shift_q;
      cur_bif    = bif_q;
      cur_skip   = skip_q;
      cur_low    = low_q;
      cur_sig    = sig_q;
      cur_terr   = terr_q;
      cur_size   = size_q;
      cur_halted = halted_q;
      cur_x      = x_q;
      cur_y      = y_q;
      cur_col    = col_q;
      cur_row    = row_q;
      cur_scale  = scale_q;
      cur_base   = base_q;
    end
  end

  assign mark_new = {cur_shift[55:0], item_i.data_byte};
  assign bif_inc  = cur_bif + 4'd1;
  assign mark_len = cur_terr ? hcp_pkg::LEN_WORD : hcp_pkg::LEN_SIG;
  assign word_new = {item_i.data_byte, cur_low};

  // SIZE counts points as size+1; every dimension saturates.
  assign dim_raw = {1'b0, word_new} + ((cur_phase == hcp_pkg::PH_SIZE) ? 17'd1 : 17'd0);
  assign dim_sat = (dim_raw > DIM_MAX) ? DIM_MAX : dim_raw;

  assign col_inc = {1'b0, cur_col} + 1'b1;
  assign row_inc = {1'b0, cur_row} + 1'b1;
  assign x_ext   = {1'b0, cur_x};
  assign y_ext   = {1'b0, cur_y};

  hcp_marker_dec u_marker_dec (
    .marker_i        (mark_new),
    .seen_signature_i(cur_sig),
    .seen_terrain_i  (cur_terr),
    .seen_size_i     (cur_size),
    .dec_o           (dec)
  );

  always_comb begin
    phase_d  = cur_phase;
    shift_d  = cur_shift;
    bif_d    = cur_bif;
    skip_d   = cur_skip;
    low_d    = cur_low;
    sig_d    = cur_sig;
    terr_d   = cur_terr;
    size_d   = cur_size;
    halted_d = cur_halted;
    x_d      = cur_x;
    y_d      = cur_y;
    col_d    = cur_col;
    row_d    = cur_row;
    scale_d  = cur_scale;
    base_d   = cur_base;
    kind     = hcp_pkg::KIND_HEADER;
    res_on   = 1'b0;
    smp      = '0;
    last     = 1'b0;

    if (!cur_halted) begin
      case (cur_phase)
        hcp_pkg::PH_MARK: begin
          shift_d = mark_new;
          bif_d   = bif_inc;
          if (bif_inc >= mark_len) begin
            shift_d = '0;
            bif_d   = '0;
            if (dec.set_signature) begin
              sig_d = 1'b1;
            end
            if (dec.set_terrain) begin
              terr_d = 1'b1;
            end
            if (dec.start) begin
              phase_d = dec.phase;
              skip_d  = dec.len;
            end
            if (dec.stop) begin
              res_on = 1'b1;
              kind   = dec.stop_kind;
            end
          end
        end
        hcp_pkg::PH_SIZE, hcp_pkg::PH_XPTS, hcp_pkg::PH_YPTS: begin
          if (cur_bif == 4'd0) begin
            low_d = item_i.data_byte;
          end else if (cur_bif == 4'd1) begin
            if (cur_phase == hcp_pkg::PH_SIZE) begin
              size_d = 1'b1;
              x_d    = DIM_BITS'(dim_sat);
              y_d    = DIM_BITS'(dim_sat);
            end else if (cur_phase == hcp_pkg::PH_XPTS) begin
              x_d = DIM_BITS'(dim_sat);
            end else begin
              y_d = DIM_BITS'(dim_sat);
            end
          end
          bif_d = bif_inc;
          if (bif_inc >= hcp_pkg::LEN_WORD) begin
            phase_d = hcp_pkg::PH_MARK;
            bif_d   = '0;
            shift_d = '0;
          end
        end
        hcp_pkg::PH_SKIP: begin
          bif_d = bif_inc;
          if (bif_inc >= cur_skip) begin
            phase_d = hcp_pkg::PH_MARK;
            bif_d   = '0;
            shift_d = '0;
          end
        end
        hcp_pkg::PH_SCALE: begin
          if (cur_bif == 4'd0) begin
            low_d = item_i.data_byte;
            bif_d = 4'd1;
          end else begin
            scale_d = word_new;
            phase_d = hcp_pkg::PH_BASE;
            skip_d  = hcp_pkg::LEN_HALF;
            bif_d   = '0;
          end
        end
        hcp_pkg::PH_BASE: begin
          if (cur_bif == 4'd0) begin
            low_d = item_i.data_byte;
            bif_d = 4'd1;
          end else begin
            base_d = word_new;
            res_on = 1'b1;
            kind   = hcp_pkg::KIND_HEADER;
            col_d  = '0;
            row_d  = '0;
            bif_d  = '0;
            // Empty grid: header only.
            if (cur_x == '0 || cur_y == '0) begin
              phase_d = hcp_pkg::PH_MARK;
              shift_d = '0;
            end else begin
              phase_d = hcp_pkg::PH_SAMPLES;
              skip_d  = hcp_pkg::LEN_HALF;
            end
          end
        end
        hcp_pkg::PH_SAMPLES: begin
          if (cur_bif == 4'd0) begin
            low_d = item_i.data_byte;
            bif_d = 4'd1;
          end else begin
            bif_d  = '0;
            smp    = word_new ^ hcp_pkg::SAMPLE_FLIP;
            res_on = 1'b1;
            kind   = hcp_pkg::KIND_SAMPLE;
            last   = (col_inc == x_ext) && (row_inc == y_ext);
            col_d  = col_inc[DIM_BITS-1:0];
            if (col_inc >= x_ext) begin
              col_d = '0;
              row_d = row_inc[DIM_BITS-1:0];
              if (row_inc >= y_ext) begin
                row_d   = '0;
                phase_d = hcp_pkg::PH_MARK;
                shift_d = '0;
              end
            end
          end
        end
        default: begin
          phase_d = hcp_pkg::PH_MARK;
          bif_d   = '0;
          shift_d = '0;
        end
      endcase

      if (res_on && (kind == hcp_pkg::KIND_END || kind == hcp_pkg::KIND_UNEXPECTED)) begin
        halted_d = 1'b1;
      end else if (item_i.final_byte) begin
        halted_d = 1'b1;
        // Truncated file replaces whatever this byte produced.
        if (phase_d != hcp_pkg::PH_MARK || bif_d != 4'd0) begin
          res_on = 1'b1;
          kind   = hcp_pkg::KIND_TRUNCATED;
          smp    = '0;
          last   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hcp_pkg::PH_MARK;
      shift_q  <= '0;
      bif_q    <= '0;
      skip_q   <= '0;
      low_q    <= '0;
      sig_q    <= 1'b0;
      terr_q   <= 1'b0;
      size_q   <= 1'b0;
      halted_q <= 1'b0;
      x_q      <= '0;
      y_q      <= '0;
      col_q    <= '0;
      row_q    <= '0;
      scale_q  <= '0;
      base_q   <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      bif_q    <= bif_d;
      skip_q   <= skip_d;
      low_q    <= low_d;
      sig_q    <= sig_d;
      terr_q   <= terr_d;
      size_q   <= size_d;
      halted_q <= halted_d;
      x_q      <= x_d;
      y_q      <= y_d;
      col_q    <= col_d;
      row_q    <= row_d;
      scale_q  <= scale_d;
      base_q   <= base_d;
    end
  end

  assign res_valid_o         = res_on;
  assign res_o.kind          = kind;
  assign res_o.sample        = smp;
  assign res_o.width_points  = DimFieldW'(x_d);
  assign res_o.height_points = DimFieldW'(y_d);
  assign res_o.height_scale  = scale_d;
  assign res_o.base_height   = base_d;
  assign res_o.last_sample   = last;

endmodule

// ===== rtl/core/heightmap_chunk_parser.sv =====
// Throughput: one item per cycle; the parser logic sits between the input
// register and the result register, and in_ready_o drops only while a
// result waits on out_ready_i with the next item already held.
// Reset: rst_ni clears all parser state and both valid flags; a byte with
// first_byte set restarts the parse without a reset.
module heightmap_chunk_parser #(
  parameter int unsigned DIM_BITS = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hcp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hcp_pkg::out_item_t out_item_o
);

  logic               in_valid_q;
  hcp_pkg::in_item_t  in_item_q;
  logic               out_valid_q;
  hcp_pkg::out_item_t out_item_q;
  logic               advance;
  logic               res_valid;
  hcp_pkg::out_item_t res;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  hcp_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (advance),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/hcp_checker.sv =====
`include "heightmap_chunk_parser_defines.svh"

module hcp_checker #(
  parameter int unsigned DIM_BITS = 17
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input hcp_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input hcp_pkg::out_item_t out_item_o
);

  localparam logic [16:0] DIM_MAX = 17'((1 << DIM_BITS) - 1);

  logic in_fire;

  assign in_fire = in_valid_i && in_ready_o && (in_item_i.data_byte == in_item_i.data_byte);

  // A rising out_valid_o must trace back to an accepted item, which passes the input register and the result register.
  `HCP_ASSERT_IMPL(a_result_has_item, clk_i, rst_ni, $rose(out_valid_o), $past(in_fire, 2))
  `HCP_ASSERT_IMPL(a_last_only_on_sample, clk_i, rst_ni, out_valid_o && out_item_o.last_sample, out_item_o.kind == hcp_pkg::KIND_SAMPLE)
  `HCP_ASSERT_IMPL(a_sample_zero_otherwise, clk_i, rst_ni, out_valid_o && out_item_o.kind != hcp_pkg::KIND_SAMPLE, out_item_o.sample == 16'd0)
  `HCP_ASSERT_IMPL(a_dims_saturate, clk_i, rst_ni, out_valid_o, out_item_o.width_points <= DIM_MAX && out_item_o.height_points <= DIM_MAX)
  `HCP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

endmodule

bind heightmap_chunk_parser hcp_checker #(.DIM_BITS(DIM_BITS)) u_hcp_checker (.*);

// ===== dv/tb_heightmap_chunk_parser.sv =====
`timescale 1ns / 1ps

module tb_heightmap_chunk_parser;

  localparam int unsigned DIM_BITS = 17;
  localparam logic [17:0] DIM_MAX = (18'd1 << DIM_BITS) - 18'd1;
  localparam int unsigned LIVE_TARGET = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned PRINT_LIMIT = 40;

  class parse_scoreboard;
    hcp_pkg::out_item_t due_results[$];
    int unsigned        errors;

    hcp_pkg::phase_e phase;
    logic [63:0]     mark_bits;
    logic [3:0]      idx;
    logic [3:0]      skip_len;
    logic [7:0]      low_byte;
    bit              sig_ok, terr_ok, size_ok, halted;
    logic [16:0]     xp, yp, col, row;
    logic [15:0]     scale, base;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = hcp_pkg::PH_MARK;
      mark_bits = '0;
      idx = '0;
      skip_len = '0;
      low_byte = '0;
      sig_ok = 0;
      terr_ok = 0;
      size_ok = 0;
      halted = 0;
      xp = '0;
      yp = '0;
      col = '0;
      row = '0;
      scale = '0;
      base = '0;
    endfunction

    function logic [16:0] clamp(logic [17:0] v);
      return (v > DIM_MAX) ? DIM_MAX[16:0] : v[16:0];
    endfunction

    function void open_field(hcp_pkg::phase_e ph, logic [3:0] len);
      phase = ph;
      skip_len = len;
      idx = '0;
    endfunction

    function void to_marker();
      phase = hcp_pkg::PH_MARK;
      idx = '0;
      mark_bits = '0;
    endfunction

    // Returns 1 when the completed marker yields a result in k.
    function bit decode_marker(output hcp_pkg::kind_e k);
      logic [63:0] m;
      logic [31:0] w;
      m = mark_bits;
      w = m[31:0];
      mark_bits = '0;
      idx = '0;
      k = hcp_pkg::KIND_UNEXPECTED;
      if (!terr_ok) begin
        if (!sig_ok && m == hcp_pkg::MARK_TERRAGEN) begin
          sig_ok = 1;
          return 0;
        end
        if (sig_ok && m == hcp_pkg::MARK_TERRAIN) begin
          terr_ok = 1;
          return 0;
        end
        if (m[63:32] == hcp_pkg::MARK_EOF) k = hcp_pkg::KIND_END;
        return 1;
      end
      if (w == hcp_pkg::MARK_SIZE) begin
        open_field(hcp_pkg::PH_SIZE, hcp_pkg::LEN_WORD);
        return 0;
      end
      if (size_ok) begin
        if (w == hcp_pkg::MARK_XPTS) begin
          open_field(hcp_pkg::PH_XPTS, hcp_pkg::LEN_WORD);
          return 0;
        end
        if (w == hcp_pkg::MARK_YPTS) begin
          open_field(hcp_pkg::PH_YPTS, hcp_pkg::LEN_WORD);
          return 0;
        end
        if (w == hcp_pkg::MARK_SCAL) begin
          open_field(hcp_pkg::PH_SKIP, hcp_pkg::LEN_SCAL);
          return 0;
        end
        if (w == hcp_pkg::MARK_CRAD) begin
          open_field(hcp_pkg::PH_SKIP, hcp_pkg::LEN_WORD);
          return 0;
        end
        if (w == hcp_pkg::MARK_CRVM) begin
          open_field(hcp_pkg::PH_SKIP, hcp_pkg::LEN_WORD);
          return 0;
        end
        if (w == hcp_pkg::MARK_ALTW) begin
          open_field(hcp_pkg::PH_SCALE, hcp_pkg::LEN_HALF);
          return 0;
        end
      end
      if (w == hcp_pkg::MARK_EOF) k = hcp_pkg::KIND_END;
      return 1;
    endfunction

    // Advance the parse by one accepted item; return 0 if the item was ignored.
    function bit take_byte(hcp_pkg::in_item_t it);
      bit                 has;
      hcp_pkg::kind_e     k;
      logic [15:0]        smp;
      logic [15:0]        word;
      bit                 last;
      logic [7:0]         b;
      hcp_pkg::out_item_t res;
      b = it.data_byte;
      has = 0;
      k = hcp_pkg::KIND_HEADER;
      smp = '0;
      last = 0;
      if (it.first_byte) restart();
      if (halted) return 0;
      case (phase)
        hcp_pkg::PH_MARK: begin
          mark_bits = {mark_bits[55:0], b};
          idx = idx + 4'd1;
          if (idx >= (terr_ok ? hcp_pkg::LEN_WORD : hcp_pkg::LEN_SIG)) begin
            has = decode_marker(k);
          end
        end
        hcp_pkg::PH_SIZE, hcp_pkg::PH_XPTS, hcp_pkg::PH_YPTS: begin
          if (idx == 4'd0) begin
            low_byte = b;
          end else if (idx == 4'd1) begin
            word = {b, low_byte};
            if (phase == hcp_pkg::PH_SIZE) begin
              size_ok = 1;
              xp = clamp({2'b00, word} + 18'd1);
              yp = xp;
            end else if (phase == hcp_pkg::PH_XPTS) begin
              xp = clamp({2'b00, word});
            end else begin
              yp = clamp({2'b00, word});
            end
          end
          idx = idx + 4'd1;
          if (idx >= hcp_pkg::LEN_WORD) to_marker();
        end
        hcp_pkg::PH_SKIP: begin
          idx = idx + 4'd1;
          if (idx >= skip_len) to_marker();
        end
        hcp_pkg::PH_SCALE: begin
          if (idx == 4'd0) begin
            low_byte = b;
            idx = 4'd1;
          end else begin
            scale = {b, low_byte};
            open_field(hcp_pkg::PH_BASE, hcp_pkg::LEN_HALF);
          end
        end
        hcp_pkg::PH_BASE: begin
          if (idx == 4'd0) begin
            low_byte = b;
            idx = 4'd1;
          end else begin
            base = {b, low_byte};
            has = 1;
            k = hcp_pkg::KIND_HEADER;
            col = '0;
            row = '0;
            if (xp == '0 || yp == '0) to_marker();
            else open_field(hcp_pkg::PH_SAMPLES, hcp_pkg::LEN_HALF);
          end
        end
        default: begin
          if (idx == 4'd0) begin
            low_byte = b;
            idx = 4'd1;
          end else begin
            idx = '0;
            smp = {b, low_byte} ^ hcp_pkg::SAMPLE_FLIP;
            has = 1;
            k = hcp_pkg::KIND_SAMPLE;
            last = (col + 17'd1 == xp) && (row + 17'd1 == yp);
            col = col + 17'd1;
            if (col >= xp) begin
              col = '0;
              row = row + 17'd1;
              if (row >= yp) begin
                row = '0;
                to_marker();
              end
            end
          end
        end
      endcase

      if (has && (k == hcp_pkg::KIND_END || k == hcp_pkg::KIND_UNEXPECTED)) begin
        halted = 1;
      end else if (it.final_byte) begin
        halted = 1;
        // an unfinished marker or payload turns this byte's result into truncated
        if (phase != hcp_pkg::PH_MARK || idx != '0) begin
          has = 1;
          k = hcp_pkg::KIND_TRUNCATED;
          smp = '0;
          last = 0;
        end
      end

      if (has) begin
        res.kind = k;
        res.sample = smp;
        res.width_points = xp;
        res.height_points = yp;
        res.height_scale = scale;
        res.base_height = base;
        res.last_sample = last;
        due_results.push_back(res);
      end
      return 1;
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task match_result(hcp_pkg::out_item_t got);
      hcp_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result of kind %0d with none outstanding", got.kind));
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", 32'(got.kind), 32'(want.kind));
      compare_field("sample", 32'(got.sample), 32'(want.sample));
      compare_field("width_points", 32'(got.width_points), 32'(want.width_points));
      compare_field("height_points", 32'(got.height_points), 32'(want.height_points));
      compare_field("height_scale", 32'(got.height_scale), 32'(want.height_scale));
      compare_field("base_height", 32'(got.base_height), 32'(want.base_height));
      compare_field("last_sample", 32'(got.last_sample), 32'(want.last_sample));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  hcp_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  hcp_pkg::out_item_t out_item;

  parse_scoreboard sb = new();

  logic [7:0]  file_bytes[$];
  int unsigned live_items = 0;
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  heightmap_chunk_parser #(
    .DIM_BITS(DIM_BITS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #10 clk = ~clk;

  // Result side: check accepted items, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.match_result(out_item);
    if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
    rx_cycle++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle % 11) < 7;
    endcase
  end

  function automatic void put_tag(logic [31:0] m);
    file_bytes.push_back(m[31:24]);
    file_bytes.push_back(m[23:16]);
    file_bytes.push_back(m[15:8]);
    file_bytes.push_back(m[7:0]);
  endfunction

  function automatic void put_half(logic [15:0] v);
    file_bytes.push_back(v[7:0]);
    file_bytes.push_back(v[15:8]);
  endfunction

  function automatic void put_head();
    put_tag(hcp_pkg::MARK_TERRAGEN[63:32]);
    put_tag(hcp_pkg::MARK_TERRAGEN[31:0]);
    put_tag(hcp_pkg::MARK_TERRAIN[63:32]);
    put_tag(hcp_pkg::MARK_TERRAIN[31:0]);
  endfunction

  // Dimension chunk: word, then two pad bytes.
  function automatic void put_dim(logic [31:0] tag, logic [15:0] v);
    put_tag(tag);
    put_half(v);
    put_half(16'($urandom));
  endfunction

  function automatic void put_skip(logic [31:0] tag, int unsigned len);
    put_tag(tag);
    repeat (len) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_samples(longint unsigned n);
    for (longint unsigned i = 0; i < n; i++) put_half(pick_word());
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 19))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(30, 150));
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic void cut_file(int unsigned keep);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
  endfunction

  task automatic send_item(hcp_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.take_byte(it)) live_items++;
  endtask

  task automatic send_file(bit with_first, bit with_final);
    hcp_pkg::in_item_t it;
    for (int i = 0; i < file_bytes.size(); i++) begin
      it.data_byte = file_bytes[i];
      it.first_byte = with_first && (i == 0);
      it.final_byte = with_final && (i == file_bytes.size() - 1);
      send_item(it);
    end
    file_bytes.delete();
  endtask

  task automatic send_noise(int unsigned n);
    hcp_pkg::in_item_t it;
    repeat (n) begin
      it.data_byte = 8'($urandom);
      it.first_byte = ($urandom_range(0, 9) == 0);
      it.final_byte = ($urandom_range(0, 9) == 0);
      send_item(it);
    end
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  task automatic send_random_file();
    int unsigned    pick, sz, slot, tmp, ending;
    longint unsigned w, h;
    logic [15:0]    xv, yv;
    bit             use_x, use_y;
    int unsigned    order[5];
    logic [31:0]    bad_tag;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_noise($urandom_range(1, 30));
      return;
    end
    put_head();
    if (pick < 12) begin
      case ($urandom_range(0, 4))
        0: bad_tag = hcp_pkg::MARK_XPTS;
        1: bad_tag = hcp_pkg::MARK_ALTW;
        2: bad_tag = hcp_pkg::MARK_SCAL;
        3: bad_tag = hcp_pkg::MARK_TERRAIN[63:32];
        default: bad_tag = $urandom;
      endcase
      put_tag(bad_tag);
    end
    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 65535) : $urandom_range(0, 3);
    w = 64'(sz) + 64'd1;
    h = 64'(sz) + 64'd1;
    put_dim(hcp_pkg::MARK_SIZE, 16'(sz));
    use_x = ($urandom_range(0, 2) == 0) || (sz >= 20);
    use_y = ($urandom_range(0, 2) == 0) || (sz >= 20);
    xv = pick_dim();
    yv = pick_dim();
    if (use_x) w = 64'(xv);
    if (use_y) h = 64'(yv);
    if (w * h > 400) begin
      use_y = 1;
      yv = '0;
      h = 0;
    end
    for (int i = 0; i < 5; i++) order[i] = i;
    for (int i = 4; i > 0; i--) begin
      slot = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[slot];
      order[slot] = tmp;
    end
    for (int i = 0; i < 5; i++) begin
      case (order[i])
        0: if (use_x) put_dim(hcp_pkg::MARK_XPTS, xv);
        1: if (use_y) put_dim(hcp_pkg::MARK_YPTS, yv);
        2: if ($urandom_range(0, 1)) put_skip(hcp_pkg::MARK_SCAL, 32'(hcp_pkg::LEN_SCAL));
        3: if ($urandom_range(0, 1)) put_skip(hcp_pkg::MARK_CRAD, 32'(hcp_pkg::LEN_WORD));
        default: if ($urandom_range(0, 1)) put_skip(hcp_pkg::MARK_CRVM, 32'(hcp_pkg::LEN_WORD));
      endcase
    end
    repeat ($urandom_range(0, 5) == 0 ? 2 : 1) begin
      put_tag(hcp_pkg::MARK_ALTW);
      put_half(pick_word());
      put_half(pick_word());
      put_samples(w * h);
    end
    ending = $urandom_range(0, 9);
    if (ending < 8) put_tag(hcp_pkg::MARK_EOF);
    else if (ending == 9) put_tag($urandom);
    // broken files: truncate or corrupt
    if ($urandom_range(0, 4) == 0) cut_file($urandom_range(1, file_bytes.size() - 1));
    if ($urandom_range(0, 9) == 0) begin
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
    end
    send_file($urandom_range(0, 19) != 0, $urandom_range(0, 9) != 0);
    if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 10));
  endtask

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // minimal 1x1 grid, extreme scale and base
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0000);
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'h7FFF);
    put_half(16'h8000);
    put_half(16'h0000);
    put_tag(hcp_pkg::MARK_EOF);
    send_file(1, 1);

    // largest SIZE overridden, all skipped chunks, extreme samples
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'hFFFF);
    put_dim(hcp_pkg::MARK_XPTS, 16'h0002);
    put_dim(hcp_pkg::MARK_YPTS, 16'h0002);
    put_skip(hcp_pkg::MARK_SCAL, 32'(hcp_pkg::LEN_SCAL));
    put_skip(hcp_pkg::MARK_CRAD, 32'(hcp_pkg::LEN_WORD));
    put_skip(hcp_pkg::MARK_CRVM, 32'(hcp_pkg::LEN_WORD));
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'h8000);
    put_half(16'h7FFF);
    put_half(16'hFFFF);
    put_half(16'h8000);
    put_half(16'h7FFF);
    put_half(16'h0000);
    put_tag(hcp_pkg::MARK_EOF);
    send_file(1, 1);

    // empty grid: header only, widest x
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0003);
    put_dim(hcp_pkg::MARK_XPTS, 16'hFFFF);
    put_dim(hcp_pkg::MARK_YPTS, 16'h0000);
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'h1234);
    put_half(16'hFEDC);
    put_tag(hcp_pkg::MARK_EOF);
    send_file(1, 1);

    // end marker in place of the signature, then after it
    put_tag(hcp_pkg::MARK_EOF);
    put_tag($urandom);
    send_file(1, 0);
    put_tag(hcp_pkg::MARK_TERRAGEN[63:32]);
    put_tag(hcp_pkg::MARK_TERRAGEN[31:0]);
    put_tag(hcp_pkg::MARK_EOF);
    put_tag(hcp_pkg::MARK_TERRAIN[63:32]);
    send_file(1, 0);

    // signature twice, terrain marker after terrain, chunk before SIZE
    put_tag(hcp_pkg::MARK_TERRAGEN[63:32]);
    put_tag(hcp_pkg::MARK_TERRAGEN[31:0]);
    put_tag(hcp_pkg::MARK_TERRAGEN[63:32]);
    put_tag(hcp_pkg::MARK_TERRAGEN[31:0]);
    send_file(1, 0);
    put_head();
    put_tag(hcp_pkg::MARK_TERRAIN[63:32]);
    send_file(1, 0);
    put_head();
    put_dim(hcp_pkg::MARK_XPTS, 16'h0004);
    send_file(1, 0);

    // truncated mid-sample, then on a completed but not final sample
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0002);
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'h0001);
    put_half(16'h0002);
    put_samples(4);
    file_bytes.push_back(8'hA5);
    send_file(1, 1);
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0001);
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'h0003);
    put_half(16'h0004);
    put_samples(1);
    send_file(1, 1);

    // final byte on the last sample, then bytes ignored while halted
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0000);
    put_tag(hcp_pkg::MARK_ALTW);
    put_half(16'hFFFF);
    put_half(16'h0000);
    put_samples(1);
    send_file(1, 1);
    put_head();
    send_file(0, 1);
    send_noise(6);

    // final byte at a chunk boundary, then a restart mid-file
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0005);
    send_file(1, 1);
    put_head();
    put_dim(hcp_pkg::MARK_SIZE, 16'h0001);
    put_tag(hcp_pkg::MARK_ALTW);
    send_file(1, 0);

    wait_drained();

    while (live_items < LIVE_TARGET) begin
      send_random_file();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.due_results.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/hcp_pkg.sv
rtl/core/hcp_marker_dec.sv
rtl/core/hcp_parser.sv
rtl/core/heightmap_chunk_parser.sv
rtl/core/hcp_checker.sv
dv/tb_heightmap_chunk_parser.sv
